FILE: rtl/circular_deque_defines.svh
// assertion macros shared by the circular deque rtl
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

`ifndef SYNTHESIS

// checked on every clock edge outside reset
`define CDQ_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define CDQ_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`else

`define CDQ_ASSERT(name, prop, msg)
`define CDQ_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

FILE: rtl/cdq_pkg.sv
// types and constants of the circular deque
package cdq_pkg;

   // store geometry
   localparam int STORE_DEPTH = 16;
   localparam int DATA_W      = 32;
   localparam int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

   // capacity register
   localparam int               CAP_W     = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(STORE_DEPTH);

   // width that holds both a count and a capacity value
   localparam int EFF_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   localparam int ACT_W = 3;

   typedef enum logic [ACT_W-1:0] {
      ACT_INSERT_FRONT = 3'd0,
      ACT_INSERT_REAR  = 3'd1,
      ACT_DELETE_FRONT = 3'd2,
      ACT_DELETE_REAR  = 3'd3,
      ACT_QUERY        = 3'd4
   } action_type;

endpackage

FILE: rtl/circular_deque.sv
// Circular deque: a double-ended queue of up to 16 signed 32-bit words kept in
// a ring store. A request is taken at any clock edge with start high (busy
// never rises) and its response appears in the next cycle, for one cycle,
// on rsp_strobe; one request per cycle is sustained. The response comes from
// the registered read of the two store copies: front and rear words are read in
// the request cycle and a word written in that same cycle is forwarded to the
// response. Writing csr_wdata sets the capacity (0 reads as 1, above 16 as 16)
// and empties the deque; write it only while no response is pending.
`include "circular_deque_defines.svh"

module circular_deque (
   input  logic                         clock,
   input  logic                         reset,
   // request beat
   input  logic                         start,
   output logic                         busy,
   input  logic [cdq_pkg::ACT_W-1:0]    req_action,
   input  logic signed [cdq_pkg::DATA_W-1:0] req_value,
   // response beat
   output logic                         rsp_strobe,
   output logic                         rsp_ok,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_front_value,
   output logic signed [cdq_pkg::DATA_W-1:0] rsp_rear_value,
   output logic                         rsp_is_empty,
   output logic                         rsp_is_full,
   output logic [cdq_pkg::CNT_W-1:0]    rsp_entry_count,
   // capacity register
   input  logic                         csr_we,
   input  logic [cdq_pkg::CAP_W-1:0]    csr_wdata
);

   import cdq_pkg::*;

   // control state
   logic [CAP_W-1:0] cap_ff;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // response stage
   logic             strobe_ff;
   logic             ok_ff, ok_in;
   logic             empty_ff, full_ff, full_in;
   logic [CNT_W-1:0] rcount_ff;
   logic             fwd_head_ff, fwd_head_in;
   logic             fwd_tail_ff, fwd_tail_in;
   logic [DATA_W-1:0] wval_ff;

   logic             accept;
   logic [EFF_W-1:0] cap_eff;
   logic [EFF_W-1:0] cap_ext;
   logic             wr_en;
   logic [IDX_W-1:0] slot;
   logic [DATA_W-1:0] rd_head, rd_tail;
   action_type       act;

   // index move toward the rear, wraps at the capacity
   function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                                input logic [EFF_W-1:0] cap);
      logic [EFF_W:0] nxt;
      nxt = (EFF_W+1)'(idx) + (EFF_W+1)'(1);
      return (nxt >= (EFF_W+1)'(cap)) ? '0 : IDX_W'(nxt);
   endfunction

   // index move toward the front, wraps at the capacity
   function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                  input logic [EFF_W-1:0] cap);
      logic [EFF_W-1:0] lim;
      lim = cap - EFF_W'(1);
      return (idx == '0 || EFF_W'(idx) > cap) ? IDX_W'(lim) : idx - IDX_W'(1);
   endfunction

   // busy is tied low, nothing ever waits
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign act    = action_type'(req_action);

   // clamp the capacity register to 1..STORE_DEPTH
   assign cap_ext = EFF_W'(cap_ff);
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = EFF_W'(1);
      end else if (cap_ext > EFF_W'(STORE_DEPTH)) begin
         cap_eff = EFF_W'(STORE_DEPTH);
      end else begin
         cap_eff = cap_ext;
      end
   end

   // next indices, count and store write for one request
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ok_in    = 1'b0;
      wr_en    = 1'b0;
      slot     = head_ff;
      case (act)
         ACT_INSERT_FRONT, ACT_INSERT_REAR: begin
            if (EFF_W'(count_ff) < cap_eff) begin
               if (count_ff == '0) begin
                  head_in = '0;
                  tail_in = '0;
                  slot    = '0;
               end else if (act == ACT_INSERT_FRONT) begin
                  head_in = step_down(head_ff, cap_eff);
                  slot    = head_in;
               end else begin
                  tail_in = step_up(tail_ff, cap_eff);
                  slot    = tail_in;
               end
               wr_en    = accept;
               count_in = count_ff + CNT_W'(1);
               ok_in    = 1'b1;
            end
         end
         ACT_DELETE_FRONT, ACT_DELETE_REAR: begin
            if (count_ff != '0) begin
               if (count_ff == CNT_W'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (act == ACT_DELETE_FRONT) begin
                  head_in = step_up(head_ff, cap_eff);
               end else begin
                  tail_in = step_down(tail_ff, cap_eff);
               end
               count_in = count_ff - CNT_W'(1);
               ok_in    = 1'b1;
            end
         end
         ACT_QUERY: begin
            ok_in = 1'b1;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   // a word written this cycle shows through at the response
   assign fwd_head_in = wr_en && (slot == head_in);
   assign fwd_tail_in = wr_en && (slot == tail_in);
   assign full_in     = (EFF_W'(count_in) == cap_eff);

   // control registers, a capacity write empties the deque after any request
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff    <= CAP_RESET;
         head_ff   <= '0;
         tail_ff   <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (csr_we) begin
            cap_ff   <= csr_wdata;
            head_ff  <= '0;
            tail_ff  <= '0;
            count_ff <= '0;
         end else if (accept) begin
            head_ff  <= head_in;
            tail_ff  <= tail_in;
            count_ff <= count_in;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (accept) begin
         ok_ff       <= ok_in;
         empty_ff    <= (count_in == '0);
         full_ff     <= full_in;
         rcount_ff   <= count_in;
         fwd_head_ff <= fwd_head_in;
         fwd_tail_ff <= fwd_tail_in;
         wval_ff     <= req_value;
      end
   end

   // two store copies, one read port each for front and rear
   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_ram_front (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (req_value),
      .rd_en   (accept),
      .rd_addr (head_in),
      .rd_data (rd_head)
   );

   cdq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STORE_DEPTH)
   ) u_ram_rear (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (req_value),
      .rd_en   (accept),
      .rd_addr (tail_in),
      .rd_data (rd_tail)
   );

   // response beat
   assign rsp_strobe      = strobe_ff;
   assign rsp_ok          = ok_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_is_full     = full_ff;
   assign rsp_entry_count = rcount_ff;
   assign rsp_front_value = empty_ff ? '1 : (fwd_head_ff ? wval_ff : rd_head);
   assign rsp_rear_value  = empty_ff ? '1 : (fwd_tail_ff ? wval_ff : rd_tail);

   // checks
   `CDQ_ASSERT(a_count_in_cap, EFF_W'(count_ff) <= cap_eff, "count above capacity")
   `CDQ_ASSERT(a_empty_idx, (count_ff == '0) |-> (head_ff == '0 && tail_ff == '0), "indices off when empty")
   `CDQ_ASSERT(a_rsp_follows, accept |=> rsp_strobe, "no response after request")
   `CDQ_ASSERT(a_rsp_only_after, rsp_strobe |-> $past(accept), "response without request")
   `CDQ_ASSERT_ALWAYS(a_empty_word, (rsp_strobe && rsp_is_empty) |-> (&rsp_front_value && &rsp_rear_value), "empty response carries data")

endmodule

FILE: rtl/cdq_ram.sv
// generic single-write, single-read ram with registered read (read-first)
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: test/cdq_checker.sv
// response checker for the circular deque: predicts each beat and compares it
`timescale 1ns / 100ps

module cdq_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [cdq_pkg::ACT_W-1:0]   req_action,
   input  logic [cdq_pkg::DATA_W-1:0]  req_value,
   input  logic                        rsp_strobe,
   input  logic                        rsp_ok,
   input  logic [cdq_pkg::DATA_W-1:0]  rsp_front_value,
   input  logic [cdq_pkg::DATA_W-1:0]  rsp_rear_value,
   input  logic                        rsp_is_empty,
   input  logic                        rsp_is_full,
   input  logic [cdq_pkg::CNT_W-1:0]   rsp_entry_count,
   input  logic                        csr_we,
   input  logic [cdq_pkg::CAP_W-1:0]   csr_wdata,
   output int                          mismatches,
   output int                          pending
);
   import cdq_pkg::*;

   typedef struct packed {
      logic              ok;
      logic [DATA_W-1:0] front_value;
      logic [DATA_W-1:0] rear_value;
      logic              is_empty;
      logic              is_full;
      logic [CNT_W-1:0]  entry_count;
   } deque_status_type;

   // shadow copy of the deque
   logic [DATA_W-1:0] ring_words [STORE_DEPTH];
   logic [IDX_W-1:0]  front_idx;
   logic [IDX_W-1:0]  rear_idx;
   logic [CNT_W-1:0]  held;
   logic [CAP_W-1:0]  capacity_reg;

   deque_status_type awaited_status [$];

   // index moves that wrap at the usable capacity
   function automatic int ring_up(int idx, int cap);
      return (idx + 1 >= cap) ? 0 : idx + 1;
   endfunction

   function automatic int ring_down(int idx, int cap);
      return (idx == 0 || idx > cap) ? cap - 1 : idx - 1;
   endfunction

   // applies one request to the shadow deque and returns the status it yields
   function automatic deque_status_type apply_request(logic [ACT_W-1:0] act,
                                                      logic [DATA_W-1:0] word);
      int               cap;
      logic [IDX_W-1:0] slot;
      deque_status_type st;
      cap = (capacity_reg == 0) ? 1 :
            (capacity_reg > STORE_DEPTH) ? STORE_DEPTH : int'(capacity_reg);
      st = '0;
      case (act)
         ACT_INSERT_FRONT, ACT_INSERT_REAR: begin
            if (held < cap) begin
               if (held == 0) begin
                  front_idx = '0;
                  rear_idx  = '0;
                  slot      = '0;
               end else if (act == ACT_INSERT_FRONT) begin
                  front_idx = IDX_W'(ring_down(int'(front_idx), cap));
                  slot      = front_idx;
               end else begin
                  rear_idx = IDX_W'(ring_up(int'(rear_idx), cap));
                  slot     = rear_idx;
               end
               ring_words[slot] = word;
               held  = held + 1'b1;
               st.ok = 1'b1;
            end
         end
         ACT_DELETE_FRONT, ACT_DELETE_REAR: begin
            if (held != 0) begin
               if (held == 1) begin
                  front_idx = '0;
                  rear_idx  = '0;
                  held      = '0;
               end else begin
                  if (act == ACT_DELETE_FRONT)
                     front_idx = IDX_W'(ring_up(int'(front_idx), cap));
                  else
                     rear_idx = IDX_W'(ring_down(int'(rear_idx), cap));
                  held = held - 1'b1;
               end
               st.ok = 1'b1;
            end
         end
         ACT_QUERY: st.ok = 1'b1;
         default: ;
      endcase
      st.front_value = (held == 0) ? '1 : ring_words[front_idx];
      st.rear_value  = (held == 0) ? '1 : ring_words[rear_idx];
      st.is_empty    = (held == 0);
      st.is_full     = (held == cap);
      st.entry_count = held;
      return st;
   endfunction

   // response beat first, then request beat, then register write
   always @(posedge clock) begin
      deque_status_type seen;
      deque_status_type want;
      if (reset) begin
         front_idx    = '0;
         rear_idx     = '0;
         held         = '0;
         capacity_reg = CAP_RESET;
         awaited_status.delete();
         mismatches = 0;
      end else begin
         if (rsp_strobe) begin
            seen = {rsp_ok, rsp_front_value, rsp_rear_value, rsp_is_empty,
                    rsp_is_full, rsp_entry_count};
            if (awaited_status.size() == 0) begin
               if (mismatches < 10)
                  $display("%0t: response beat with nothing awaited", $realtime);
               mismatches++;
            end else begin
               want = awaited_status.pop_front();
               if (seen !== want) begin
                  if (mismatches < 10)
                     $display({"%0t: mismatch ok %0b/%0b front %h/%h rear %h/%h ",
                               "empty %0b/%0b full %0b/%0b count %0d/%0d (exp/act)"},
                              $realtime, want.ok, seen.ok, want.front_value,
                              seen.front_value, want.rear_value, seen.rear_value,
                              want.is_empty, seen.is_empty, want.is_full,
                              seen.is_full, want.entry_count, seen.entry_count);
                  mismatches++;
               end
            end
         end
         if (start && !busy)
            awaited_status.push_back(apply_request(req_action, req_value));
         // capacity write empties the deque
         if (csr_we) begin
            capacity_reg = csr_wdata;
            front_idx    = '0;
            rear_idx     = '0;
            held         = '0;
         end
      end
      pending = awaited_status.size();
   end

endmodule

FILE: test/tb_circular_deque.sv
// stimulus and verdict for the circular deque
`timescale 1ns / 100ps

module tb_circular_deque;
   import cdq_pkg::*;

   // action codes the block refuses
   localparam logic [ACT_W-1:0] ACT_RESERVED_A = 3'd5;
   localparam logic [ACT_W-1:0] ACT_RESERVED_B = 3'd6;
   localparam logic [ACT_W-1:0] ACT_RESERVED_C = 3'd7;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1550;
   localparam int PHASES       = 10;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [ACT_W-1:0]       req_action;
   logic signed [DATA_W-1:0] req_value;
   logic                   rsp_strobe;
   logic                   rsp_ok;
   logic signed [DATA_W-1:0] rsp_front_value;
   logic signed [DATA_W-1:0] rsp_rear_value;
   logic                   rsp_is_empty;
   logic                   rsp_is_full;
   logic [CNT_W-1:0]       rsp_entry_count;
   logic                   csr_we;
   logic [CAP_W-1:0]       csr_wdata;

   int mismatches;
   int pending;
   int cycle_count = 0;
   bit burst_mode;

   circular_deque dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_ok          (rsp_ok),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_entry_count (rsp_entry_count),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   cdq_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_strobe      (rsp_strobe),
      .rsp_ok          (rsp_ok),
      .rsp_front_value (rsp_front_value),
      .rsp_rear_value  (rsp_rear_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_entry_count (rsp_entry_count),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatches      (mismatches),
      .pending         (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // data word with the extremes drawn often
   function automatic logic [DATA_W-1:0] draw_word();
      case ($urandom_range(0, 11))
         0:       return {1'b1, {(DATA_W-1){1'b0}}};
         1:       return {1'b0, {(DATA_W-1){1'b1}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // action drawn with the given percentage of inserts
   function automatic logic [ACT_W-1:0] draw_action(int insert_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         case ($urandom_range(0, 2))
            0:       return ACT_RESERVED_A;
            1:       return ACT_RESERVED_B;
            default: return ACT_RESERVED_C;
         endcase
      end
      if (r < 8)
         return ACT_QUERY;
      if (r < 8 + insert_pct)
         return $urandom_range(0, 1) ? ACT_INSERT_FRONT : ACT_INSERT_REAR;
      return $urandom_range(0, 1) ? ACT_DELETE_FRONT : ACT_DELETE_REAR;
   endfunction

   // one request beat, then the sender's gap
   task automatic send_request(logic [ACT_W-1:0] act, logic [DATA_W-1:0] word);
      int gap;
      @(negedge clock);
      start      <= 1'b1;
      req_action <= act;
      req_value  <= word;
      do @(posedge clock); while (busy);
      gap = burst_mode ? 0 : $urandom_range(0, 19);
      repeat (gap) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // hold off until every awaited response beat has come
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // capacity write while idle
   task automatic write_capacity(logic [CAP_W-1:0] cap);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= cap;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // stimulus
   initial begin
      logic [CAP_W-1:0] phase_caps [PHASES];
      int per_phase;
      int left;
      int run_len;
      int bias;
      start      = 1'b0;
      req_action = ACT_QUERY;
      req_value  = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      reset      = 1'b1;
      burst_mode = 1'b0;
      phase_caps = '{5'd31, 5'd16, 5'd17, 5'd1, 5'd0, 5'd2, 5'd5, 5'd8, 5'd12, 5'd3};
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      // directed: empty refusals, extremes, reserved codes, last entry out
      send_request(ACT_QUERY, '0);
      send_request(ACT_DELETE_FRONT, '0);
      send_request(ACT_DELETE_REAR, '0);
      send_request(ACT_RESERVED_A, 32'h1234_5678);
      send_request(ACT_INSERT_FRONT, 32'h8000_0000);
      send_request(ACT_INSERT_REAR, 32'h7fff_ffff);
      send_request(ACT_INSERT_FRONT, 32'hffff_ffff);
      send_request(ACT_INSERT_REAR, 32'h0000_0000);
      send_request(ACT_RESERVED_C, 32'hdead_beef);
      send_request(ACT_DELETE_FRONT, '0);
      send_request(ACT_DELETE_REAR, '0);
      send_request(ACT_RESERVED_B, '0);
      send_request(ACT_DELETE_FRONT, '0);
      send_request(ACT_DELETE_REAR, '0);
      send_request(ACT_QUERY, '0);

      // directed: zero capacity acts as one, full refusal
      write_capacity(5'd0);
      send_request(ACT_INSERT_REAR, 32'h5555_5555);
      send_request(ACT_INSERT_FRONT, 32'haaaa_aaaa);
      send_request(ACT_DELETE_FRONT, '0);

      // directed: front inserts wrap below entry zero
      write_capacity(5'd3);
      send_request(ACT_INSERT_FRONT, 32'd1);
      send_request(ACT_INSERT_FRONT, 32'd2);
      send_request(ACT_INSERT_FRONT, 32'd3);
      send_request(ACT_INSERT_REAR, 32'd4);
      send_request(ACT_DELETE_REAR, '0);
      send_request(ACT_DELETE_REAR, '0);

      // random phases, one capacity each, runs that fill and drain
      per_phase = RANDOM_ITEMS / PHASES;
      for (int p = 0; p < PHASES; p++) begin
         write_capacity((p == PHASES - 1) ? CAP_W'($urandom) : phase_caps[p]);
         left = per_phase;
         while (left > 0) begin
            run_len = $urandom_range(8, 30);
            if (run_len > left)
               run_len = left;
            case ($urandom_range(0, 2))
               0:       bias = 70;
               1:       bias = 22;
               default: bias = 46;
            endcase
            burst_mode = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < run_len; i++)
               send_request(draw_action(bias), draw_word());
            left -= run_len;
            // sender pause mid phase
            if (left < per_phase / 2 && left + run_len >= per_phase / 2)
               drain();
         end
      end

      // final drain, then a wait for any stray beat
      drain();
      repeat (4) @(negedge clock);
      if (mismatches == 0 && pending == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
